/* hw/rtl/assert_macros.svh */
// Assertion helpers shared by the RTL modules.
// Each macro expects clk and rst_n in scope; checks are off while in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// When ante holds at one edge, cons must hold at the next.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/blm_pkg.sv */
`default_nettype none

package blm_pkg;

  // Result field widths
  localparam int MV_OUT_W  = 13;
  localparam int PCT_W     = 7;
  localparam int LVL_W     = 2;
  localparam int RUN_W     = 8;

  // Saturation point of the millivolt output
  localparam logic [MV_OUT_W-1:0] MV_MAX = 13'd8191;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_PERSIST  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CRITICAL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WARNING  = 2'd2;
  localparam int CFG_DATA_W = 8;

  // Register reset values
  localparam logic [RUN_W-1:0] PERSIST_RST  = 8'd20;
  localparam logic [PCT_W-1:0] CRITICAL_RST = 7'd5;
  localparam logic [PCT_W-1:0] WARNING_RST  = 7'd15;

  // Low-battery level codes
  localparam logic [LVL_W-1:0] LVL_NORMAL = 2'd0;
  localparam logic [LVL_W-1:0] LVL_WARN   = 2'd1;
  localparam logic [LVL_W-1:0] LVL_CRIT   = 2'd2;

  // Discharge curve: descending thresholds (mV) and matching charge percent
  localparam int NPTS  = 13;
  localparam int THR_W = 13;
  localparam logic [THR_W-1:0] VOLT_THR [NPTS] = '{
    13'd4100, 13'd4080, 13'd4000, 13'd3930, 13'd3870, 13'd3820, 13'd3790,
    13'd3770, 13'd3730, 13'd3700, 13'd3680, 13'd3500, 13'd3400
  };
  localparam logic [PCT_W-1:0] PCT_LVL [NPTS] = '{
    7'd100, 7'd90, 7'd80, 7'd70, 7'd60, 7'd50, 7'd40,
    7'd30, 7'd20, 7'd15, 7'd10, 7'd5, 7'd0
  };

  // Threshold settings shared with the level tracker
  typedef struct packed {
    logic [RUN_W-1:0] persist_count;
    logic [PCT_W-1:0] critical_percent;
    logic [PCT_W-1:0] warning_percent;
  } cfg_t;

endpackage

`default_nettype wire

/* hw/rtl/blm_level_track.sv */
`default_nettype none

`include "assert_macros.svh"

module blm_level_track (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       upd,
  input  wire logic [blm_pkg::PCT_W-1:0]  cap,
  input  wire blm_pkg::cfg_t              cfg,
  output logic      [blm_pkg::LVL_W-1:0]  lvl
);
  import blm_pkg::*;

  logic [RUN_W-1:0] crit_run_r, crit_run_nxt;
  logic [RUN_W-1:0] warn_run_r, warn_run_nxt;
  logic [LVL_W-1:0] lvl_r, lvl_nxt;
  logic [RUN_W-1:0] crit_inc;
  logic [RUN_W-1:0] warn_inc;
  logic             cap_high;

  assign crit_inc = crit_run_r + 8'd1;
  assign warn_inc = warn_run_r + 8'd1;

  // Capacity above both thresholds
  assign cap_high = cap > cfg.critical_percent && cap > cfg.warning_percent;

  // Persistence counters; critical test takes priority over warning
  always_comb begin
    crit_run_nxt = crit_run_r;
    warn_run_nxt = warn_run_r;
    lvl_nxt      = lvl_r;
    if (upd) begin
      if (cap <= cfg.critical_percent) begin
        warn_run_nxt = '0;
        if (crit_inc >= cfg.persist_count) begin
          crit_run_nxt = '0;
          lvl_nxt      = LVL_CRIT;
        end else begin
          crit_run_nxt = crit_inc;
        end
      end else if (cap <= cfg.warning_percent) begin
        crit_run_nxt = '0;
        if (warn_inc >= cfg.persist_count) begin
          warn_run_nxt = '0;
          lvl_nxt      = LVL_WARN;
        end else begin
          warn_run_nxt = warn_inc;
        end
      end else begin
        crit_run_nxt = '0;
        warn_run_nxt = '0;
        lvl_nxt      = LVL_NORMAL;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crit_run_r <= '0;
      warn_run_r <= '0;
      lvl_r      <= LVL_NORMAL;
    end else begin
      crit_run_r <= crit_run_nxt;
      warn_run_r <= warn_run_nxt;
      lvl_r      <= lvl_nxt;
    end
  end

  assign lvl = lvl_r;

  // At most one run counter is active at a time
  `ASSERT_ALWAYS(a_one_run, crit_run_r == '0 || warn_run_r == '0, "both run counters active")
  // Healthy capacity drops the level at once
  `ASSERT_NEXT(a_clear, upd && cap_high, lvl_r == LVL_NORMAL, "level not cleared")
  // Level only moves on an update
  `ASSERT_NEXT(a_hold, !upd, $stable(lvl_r), "level changed without a word")

endmodule

`default_nettype wire

/* hw/rtl/battery_level_monitor.sv */
// Channel | Direction | Handshake          | Payload
// --------+-----------+--------------------+-------------------------------------------
// in      | input     | in_valid/in_stall   | in_adc_sample
// out     | output    | out_valid/out_stall | out_battery_mv, out_capacity_percent,
//         |           |                    | out_low_level
// cfg     | input     | cfg_we             | cfg_index, cfg_wdata
//
// Throughput is one word per cycle while out_stall is low.
// Three register stages: input, scaled voltage (one constant multiply), result.
// Each stage refills as soon as it empties, so idle gaps are absorbed downstream.
// Reset (synchronous, rst_n low) empties the pipe, clears the run counters and level,
// and loads the threshold registers with their defaults.
// in_stall rises only when all three stages hold words and out_stall is high.

`default_nettype none

`include "assert_macros.svh"

module battery_level_monitor #(
  parameter int ADC_BITS = 12
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // Sample channel
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [ADC_BITS-1:0]                in_adc_sample,
  // Result channel
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic      [blm_pkg::MV_OUT_W-1:0]       out_battery_mv,
  output logic      [blm_pkg::PCT_W-1:0]          out_capacity_percent,
  output logic      [blm_pkg::LVL_W-1:0]          out_low_level,
  // Configuration writes
  input  wire logic                               cfg_we,
  input  wire logic [blm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [blm_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import blm_pkg::*;

  // mv = floor(sample * 27 / 25) as (sample * K) >> SH, exact for all samples
  localparam int SH     = ADC_BITS + 5;
  localparam int K_W    = SH + 1;
  localparam int MUL_K  = ((27 * (2 ** SH)) + 24) / 25;
  localparam int PROD_W = ADC_BITS + K_W;
  localparam int MV_W   = ADC_BITS + 1;
  localparam int CMP_W  = (MV_W > MV_OUT_W) ? MV_W : MV_OUT_W;

  localparam logic [K_W-1:0] MUL_K_V = K_W'(MUL_K);

  // Configuration registers
  logic [RUN_W-1:0] persist_r;
  logic [PCT_W-1:0] critical_r;
  logic [PCT_W-1:0] warning_r;
  cfg_t             cfg;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      persist_r  <= PERSIST_RST;
      critical_r <= CRITICAL_RST;
      warning_r  <= WARNING_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PERSIST:  persist_r  <= cfg_wdata;
        CFG_CRITICAL: critical_r <= cfg_wdata[PCT_W-1:0];
        CFG_WARNING:  warning_r  <= cfg_wdata[PCT_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.persist_count    = persist_r;
  assign cfg.critical_percent = critical_r;
  assign cfg.warning_percent  = warning_r;

  // Pipeline stage flags and flow control
  logic s1_v_r, s2_v_r, out_v_r;
  logic s1_load, s2_load, s3_load;
  logic s1_adv, s2_adv;

  assign s3_load  = !out_v_r || !out_stall;
  assign s2_adv   = s2_v_r && s3_load;
  assign s2_load  = !s2_v_r || s3_load;
  assign s1_adv   = s1_v_r && s2_load;
  assign s1_load  = !s1_v_r || s2_load;
  assign in_stall = !s1_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (s1_load) s1_v_r  <= in_valid;
      if (s2_load) s2_v_r  <= s1_adv;
      if (s3_load) out_v_r <= s2_adv;
    end
  end

  // Stage 1: input register
  logic [ADC_BITS-1:0] s1_sample_r;

  always_ff @(posedge clk) begin
    if (s1_load && in_valid) s1_sample_r <= in_adc_sample;
  end

  // Stage 2: scale to millivolts
  logic [PROD_W-1:0] prod;
  logic [MV_W-1:0]   s2_mv_r;

  assign prod = PROD_W'(s1_sample_r) * PROD_W'(MUL_K_V);

  always_ff @(posedge clk) begin
    if (s1_adv) s2_mv_r <= prod[SH +: MV_W];
  end

  // Stage 3: table lookup, saturation and level tracking
  logic [CMP_W-1:0]    mv_ext;
  logic [PCT_W-1:0]    cap;
  logic [MV_OUT_W-1:0] mv_sat;

  assign mv_ext = CMP_W'(s2_mv_r);

  // First table entry met from the top wins; below the last gives zero
  always_comb begin
    cap = '0;
    for (int k = NPTS - 1; k >= 0; k--) begin
      if (mv_ext >= CMP_W'(VOLT_THR[k])) cap = PCT_LVL[k];
    end
  end

  assign mv_sat = (mv_ext > CMP_W'(MV_MAX)) ? MV_MAX : mv_ext[MV_OUT_W-1:0];

  logic [MV_OUT_W-1:0] out_mv_r;
  logic [PCT_W-1:0]    out_cap_r;

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      out_mv_r  <= mv_sat;
      out_cap_r <= cap;
    end
  end

  blm_level_track u_track (
    .clk   (clk),
    .rst_n (rst_n),
    .upd   (s2_adv),
    .cap   (cap),
    .cfg   (cfg),
    .lvl   (out_low_level)
  );

  assign out_valid            = out_v_r;
  assign out_battery_mv       = out_mv_r;
  assign out_capacity_percent = out_cap_r;

  // An empty result register never back-pressures the input
  `ASSERT_ALWAYS(a_no_false_stall, out_v_r || !in_stall, "input stalled with empty output")
  // Delivered charge stays on the table
  `ASSERT_ALWAYS(a_cap_range, !out_v_r || out_cap_r <= 7'd100, "capacity above full scale")
  // A word taken into stage 3 shows up as a valid result next cycle
  `ASSERT_NEXT(a_s3_fill, s2_adv, out_v_r, "result lost between stages")

endmodule

`default_nettype wire

/* bench/battery_level_monitor_tb.sv */
`default_nettype none

module battery_level_monitor_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import blm_pkg::*;

  localparam int ADC_W = 12;
  localparam int IDLE_PCT = 32;
  localparam int DRAIN_CYCLES = 8;
  localparam int LIMIT_CYCLES = 200000;
  localparam int MAX_PRINTS = 50;

  // Index past the register list; writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  // Band a capacity falls in under the current thresholds
  localparam int BAND_CRIT = 0;
  localparam int BAND_WARN = 1;
  localparam int BAND_NORM = 2;

  // Discharge curve, kept independent of the RTL package
  localparam int unsigned SOC_MV [13] = '{
    4100, 4080, 4000, 3930, 3870, 3820, 3790, 3770, 3730, 3700, 3680, 3500, 3400
  };
  localparam int unsigned SOC_PCT [13] = '{
    100, 90, 80, 70, 60, 50, 40, 30, 20, 15, 10, 5, 0
  };

  typedef struct packed {
    logic [MV_OUT_W-1:0] mv;
    logic [PCT_W-1:0]    pct;
    logic [LVL_W-1:0]    lvl;
  } gauge_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [ADC_W-1:0] in_adc_sample = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [MV_OUT_W-1:0] out_battery_mv;
  logic [PCT_W-1:0] out_capacity_percent;
  logic [LVL_W-1:0] out_low_level;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Stimulus and expectation stores
  logic [ADC_W-1:0] adc_q [$];
  gauge_word_t gauge_expect_q [$];
  gauge_word_t mon_want;

  // Predictor copy of the threshold registers and the level tracker
  logic [RUN_W-1:0] cur_persist = PERSIST_RST;
  logic [PCT_W-1:0] cur_crit = CRITICAL_RST;
  logic [PCT_W-1:0] cur_warn = WARNING_RST;
  logic [RUN_W-1:0] crit_run = '0;
  logic [RUN_W-1:0] warn_run = '0;
  logic [LVL_W-1:0] level_now = LVL_NORMAL;

  int errors = 0;
  int cycles = 0;
  int hold_req = 0;
  int stall_left = 0;
  bit calm = 1'b0;

  battery_level_monitor #(.ADC_BITS(ADC_W)) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_adc_sample(in_adc_sample),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_battery_mv(out_battery_mv),
    .out_capacity_percent(out_capacity_percent),
    .out_low_level(out_low_level),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic int unsigned scale_mv(input logic [ADC_W-1:0] s);
    return ({20'd0, s} * 32'd108) / 32'd100;
  endfunction

  function automatic logic [PCT_W-1:0] soc_lookup(input int unsigned mv);
    int k;
    for (k = 0; k < 13; k++) begin
      if (mv >= SOC_MV[k]) return PCT_W'(SOC_PCT[k]);
    end
    return '0;
  endfunction

  function automatic int band_of(input logic [PCT_W-1:0] pct);
    if (pct <= cur_crit) return BAND_CRIT;
    if (pct <= cur_warn) return BAND_WARN;
    return BAND_NORM;
  endfunction

  // One sample through the gauge: voltage, charge and persistent low level
  function automatic gauge_word_t gauge_step(input logic [ADC_W-1:0] s);
    int unsigned mv;
    gauge_word_t w;
    mv = scale_mv(s);
    w.pct = soc_lookup(mv);
    if (w.pct <= cur_crit) begin
      crit_run = crit_run + 8'd1;
      warn_run = '0;
      if (crit_run >= cur_persist) begin
        crit_run = '0;
        level_now = LVL_CRIT;
      end
    end else if (w.pct <= cur_warn) begin
      crit_run = '0;
      warn_run = warn_run + 8'd1;
      if (warn_run >= cur_persist) begin
        warn_run = '0;
        level_now = LVL_WARN;
      end
    end else begin
      crit_run = '0;
      warn_run = '0;
      level_now = LVL_NORMAL;
    end
    w.mv = (mv > 32'(MV_MAX)) ? MV_MAX : mv[MV_OUT_W-1:0];
    w.lvl = level_now;
    return w;
  endfunction

  // Mostly in the battery range so every table step gets hit
  function automatic logic [ADC_W-1:0] sample_in_band(input int band);
    logic [ADC_W-1:0] s;
    int tries;
    s = '0;
    for (tries = 0; tries < 64; tries++) begin
      if ($urandom_range(0, 7) == 0) s = ADC_W'($urandom_range(0, 4095));
      else s = ADC_W'($urandom_range(3100, 4095));
      if (band_of(soc_lookup(scale_mv(s))) == band) return s;
    end
    return s;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    if (errors <= MAX_PRINTS)
      $display("%0t ns: %s mismatch, got %0d, expected %0d", $realtime, what, got, want);
  endtask

  // Mostly runs in one band around the persist length, some near misses and noise
  task automatic push_random(input int count);
    int left;
    int run;
    int band;
    int k;
    left = count;
    while (left > 0) begin
      if ($urandom_range(0, 9) < 7) begin
        band = int'($urandom_range(BAND_CRIT, BAND_NORM));
        run = int'(cur_persist) + int'($urandom_range(0, 3));
        if ($urandom_range(0, 3) == 0 && cur_persist > 1) run = int'(cur_persist) - 1;
        if (run < 1) run = 1;
        for (k = 0; k < run && left > 0; k++) begin
          adc_q.push_back(sample_in_band(band));
          left--;
        end
      end else begin
        run = int'($urandom_range(1, 4));
        for (k = 0; k < run && left > 0; k++) begin
          adc_q.push_back(ADC_W'($urandom_range(0, 4095)));
          left--;
        end
      end
    end
  endtask

  // Sampled at the falling edge so the driver and monitor have settled
  task automatic wait_drained();
    @(negedge clk);
    while (adc_q.size() != 0 || in_valid || gauge_expect_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      CFG_PERSIST: cur_persist = data;
      CFG_CRITICAL: cur_crit = data[PCT_W-1:0];
      CFG_WARNING: cur_warn = data[PCT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_thresholds(input logic [CFG_DATA_W-1:0] persist,
                                input logic [CFG_DATA_W-1:0] crit,
                                input logic [CFG_DATA_W-1:0] warn);
    wait_drained();
    write_reg(CFG_PERSIST, persist);
    write_reg(CFG_CRITICAL, crit);
    write_reg(CFG_WARNING, warn);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Sample driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) gauge_expect_q.push_back(gauge_step(in_adc_sample));
      if (!in_valid || !in_stall) begin
        if (adc_q.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
          in_valid <= 1'b1;
          in_adc_sample <= adc_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (gauge_expect_q.size() == 0) begin
          report_mismatch("unexpected word, battery_mv", int'(out_battery_mv), -1);
        end else begin
          mon_want = gauge_expect_q.pop_front();
          if (out_battery_mv !== mon_want.mv)
            report_mismatch("battery_mv", int'(out_battery_mv), int'(mon_want.mv));
          if (out_capacity_percent !== mon_want.pct)
            report_mismatch("capacity_percent", int'(out_capacity_percent),
                            int'(mon_want.pct));
          if (out_low_level !== mon_want.lvl)
            report_mismatch("low_level", int'(out_low_level), int'(mon_want.lvl));
        end
      end
      if (hold_req != 0) begin
        stall_left = hold_req;
        hold_req = 0;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
      end
    end
  end

  initial begin
    int k;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Default thresholds: field extremes, alternating bits, every table step
    adc_q.push_back(12'h000);
    adc_q.push_back(12'hFFF);
    adc_q.push_back(12'hAAA);
    adc_q.push_back(12'h555);
    adc_q.push_back(ADC_W'((SOC_MV[12] * 100 + 107) / 108 - 1));  // below every step
    for (k = 0; k < 13; k++) adc_q.push_back(ADC_W'((SOC_MV[k] * 100 + 107) / 108));
    push_random(150);

    // Zero persist count: level rises on the first low sample
    set_thresholds(8'd0, 8'd5, 8'd15);
    adc_q.push_back(sample_in_band(BAND_CRIT));
    adc_q.push_back(sample_in_band(BAND_WARN));
    adc_q.push_back(sample_in_band(BAND_NORM));
    adc_q.push_back(sample_in_band(BAND_WARN));
    adc_q.push_back(sample_in_band(BAND_CRIT));
    push_random(100);

    // Top bits of the percent writes are dropped: 20 and 127
    set_thresholds(8'd1, 8'h94, 8'hFF);
    push_random(100);

    // Critical above warning
    set_thresholds(8'd3, 8'd60, 8'd30);
    push_random(150);

    // Longest persist; a write past the register list must change nothing
    set_thresholds(8'd255, 8'd10, 8'd50);
    write_reg(CFG_SPARE, 8'h00);
    @(posedge clk);
    cfg_we <= 1'b0;
    push_random(300);

    // Back to back on both sides
    set_thresholds(8'd5, 8'd0, 8'd100);
    calm = 1'b1;
    push_random(150);
    wait_drained();
    calm = 1'b0;

    // Receiver holds off while samples keep coming, then the sender waits it out
    set_thresholds(8'd2, 8'd15, 8'd40);
    hold_req = 80;
    push_random(40);
    wait_drained();
    push_random(110);

    wait_drained();
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
